@@ rtl/handshake_message_deframer_assert.svh @@
// Assertion macros shared by the deframer checkers.
`ifndef HANDSHAKE_MESSAGE_DEFRAMER_ASSERT_SVH
`define HANDSHAKE_MESSAGE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HMD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

@@ rtl/hmd_pkg.sv @@
// Package with the types, codes and lookup functions of the message deframer.
`timescale 1ns / 1ps
package hmd_pkg;

    // Default depth of the queue between the framing front and the verdict back.
    localparam int QUEUE_DEPTH = 2;

    // Header layout: four type bytes, then two length bytes.
    localparam logic [2:0] HDR_TYPE_BYTES = 3'd4;
    localparam logic [2:0] HDR_LAST       = 3'd5;

    // Identification frame layout.
    localparam logic [15:0] SIG_LEN       = 16'd8;
    localparam logic [15:0] VER_HI_POS    = 16'd8;
    localparam logic [15:0] VER_LO_POS    = 16'd9;
    localparam logic [15:0] MIN_IDENT_LEN = 16'd10;

    typedef enum logic [2:0] {
        CLS_IDENT   = 3'd0,
        CLS_NAME    = 3'd1,
        CLS_AVATAR  = 3'd2,
        CLS_PUBID   = 3'd3,
        CLS_PUBKEY  = 3'd4,
        CLS_PAIR    = 3'd5,
        CLS_STLS    = 3'd6,
        CLS_UNKNOWN = 3'd7
    } t_class;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_DELIVER = 3'd1,
        ACT_IDENT   = 3'd2,
        ACT_ABORT   = 3'd3,
        ACT_UPGRADE = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        PH_RUN      = 2'd0,
        PH_ABORTED  = 2'd1,
        PH_UPGRADED = 2'd2
    } t_phase;

    // Four-character type codes, indexed by class.
    localparam logic [31:0] TYPE_CODES [7] = '{
        32'h64736D73, // dsms
        32'h666E616D, // fnam
        32'h61767472, // avtr
        32'h70756269, // pubi
        32'h7075626B, // pubk
        32'h70616972, // pair
        32'h73746C73  // stls
    };

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0]  data;
        logic        is_payload;
        logic        is_end;
        t_class      cls;
        logic        ident_ok;
        logic [15:0] version;
    } t_token;

    function automatic t_class classify(input logic [31:0] code);
        t_class c;
        c = CLS_UNKNOWN;
        for (int i = 6; i >= 0; i--) begin
            if (code == TYPE_CODES[i]) begin
                c = t_class'(3'(i));
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h44;
            3'd1:    v = 8'h65;
            3'd2:    v = 8'h73;
            3'd3:    v = 8'h6B;
            3'd4:    v = 8'h65;
            3'd5:    v = 8'h6D;
            3'd6:    v = 8'h65;
            default: v = 8'h73;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/hmd_if.sv @@
// Stream interfaces for received bytes and for deframed results.
`timescale 1ns / 1ps
interface hmd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface hmd_result_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [2:0]  msg_class;
    logic        msg_end;
    logic [2:0]  action;
    logic [15:0] remote_version;
    logic        forwarded;

    modport source (
        output valid, output payload_valid, output payload_byte, output msg_class,
        output msg_end, output action, output remote_version, output forwarded,
        input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input msg_class,
        input msg_end, input action, input remote_version, input forwarded,
        output ready
    );
endinterface

@@ rtl/hmd_front.sv @@
// Framing front: splits the byte stream into header and payload and classifies each byte.
`timescale 1ns / 1ps
module hmd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hmd_byte_if.sink        i_rx,
    input  logic            i_q_ready,
    output logic            o_q_valid,
    output hmd_pkg::t_token o_tok
);

    logic            r_in_payload, n_in_payload;
    logic [2:0]      r_hdr_cnt, n_hdr_cnt;
    logic [31:0]     r_type, n_type;
    logic [15:0]     r_len, n_len;
    logic [15:0]     r_pcnt, n_pcnt;
    logic            r_sig_ok, n_sig_ok;
    logic [15:0]     r_ver, n_ver;
    hmd_pkg::t_class r_cls, n_cls;
    logic            accept;
    logic [7:0]      b;

    assign i_rx.ready = i_q_ready;
    assign o_q_valid  = i_rx.valid;
    assign accept     = i_rx.valid && i_q_ready;
    assign b          = i_rx.rx_byte;

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_type       = r_type;
        n_len        = r_len;
        n_pcnt       = r_pcnt;
        n_sig_ok     = r_sig_ok;
        n_ver        = r_ver;
        n_cls        = r_cls;
        o_tok        = '{data: b, is_payload: 1'b0, is_end: 1'b0,
                         cls: hmd_pkg::CLS_IDENT, ident_ok: 1'b0, version: 16'd0};
        if (!r_in_payload) begin
            if (r_hdr_cnt < hmd_pkg::HDR_TYPE_BYTES) begin
                n_type = {r_type[23:0], b};
            end else begin
                n_len = {r_len[7:0], b};
            end
            if (r_hdr_cnt >= hmd_pkg::HDR_LAST) begin
                n_pcnt    = 16'd0;
                n_sig_ok  = 1'b1;
                n_ver     = 16'd0;
                n_cls     = hmd_pkg::classify(r_type);
                n_hdr_cnt = 3'd0;
                if (n_len == 16'd0) begin
                    // Empty frame: the last header byte also ends the frame.
                    o_tok.is_end = 1'b1;
                    o_tok.cls    = n_cls;
                end else begin
                    n_in_payload = 1'b1;
                end
            end else begin
                n_hdr_cnt = r_hdr_cnt + 3'd1;
            end
        end else begin
            o_tok.is_payload = 1'b1;
            o_tok.cls        = r_cls;
            if (r_pcnt < hmd_pkg::SIG_LEN) begin
                if (b != hmd_pkg::sig_byte(r_pcnt[2:0])) begin
                    n_sig_ok = 1'b0;
                end
            end else if (r_pcnt == hmd_pkg::VER_HI_POS) begin
                n_ver = {b, 8'h00};
            end else if (r_pcnt == hmd_pkg::VER_LO_POS) begin
                n_ver = {r_ver[15:8], b};
            end
            n_pcnt = r_pcnt + 16'd1;
            if (n_pcnt == r_len) begin
                n_in_payload   = 1'b0;
                o_tok.is_end   = 1'b1;
                o_tok.ident_ok = (r_len >= hmd_pkg::MIN_IDENT_LEN) && n_sig_ok;
                o_tok.version  = n_ver;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= 3'd0;
            r_type       <= 32'd0;
            r_len        <= 16'd0;
            r_pcnt       <= 16'd0;
            r_sig_ok     <= 1'b1;
            r_ver        <= 16'd0;
            r_cls        <= hmd_pkg::CLS_IDENT;
        end else if (accept) begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_type       <= n_type;
            r_len        <= n_len;
            r_pcnt       <= n_pcnt;
            r_sig_ok     <= n_sig_ok;
            r_ver        <= n_ver;
            r_cls        <= n_cls;
        end
    end

endmodule

@@ rtl/hmd_fifo.sv @@
// Short queue of classified bytes between the framing front and the verdict back.
`timescale 1ns / 1ps
module hmd_fifo #(
    parameter int Depth = hmd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  hmd_pkg::t_token i_push_tok,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output hmd_pkg::t_token o_pop_tok
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    hmd_pkg::t_token r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            push, pop;

    assign o_push_ready = (r_count != CntW'(Depth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_tok    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/hmd_back.sv @@
// Verdict back: judges completed frames, tracks the session phase and drives the result register.
`timescale 1ns / 1ps
module hmd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    output logic            o_tok_ready,
    input  hmd_pkg::t_token i_tok,
    hmd_result_if.source    o_res
);

    hmd_pkg::t_phase  r_phase, n_phase;
    hmd_pkg::t_action act;
    logic             r_ident, n_ident;
    logic [15:0]      r_ver, n_ver;
    logic             r_out_valid;
    logic             pop;

    logic             r_pv, n_pv;
    logic [7:0]       r_pb, n_pb;
    logic [2:0]       r_cls, n_cls;
    logic             r_end, n_end;
    logic [2:0]       r_act, n_act;
    logic             r_fwd, n_fwd;
    logic [15:0]      r_rver;

    assign o_tok_ready = !r_out_valid || o_res.ready;
    assign pop         = i_tok_valid && o_tok_ready;

    // Verdict on a frame-end byte.
    always_comb begin
        act = hmd_pkg::ACT_NONE;
        if (i_tok.is_end) begin
            if (!r_ident && i_tok.cls != hmd_pkg::CLS_IDENT) begin
                act = hmd_pkg::ACT_ABORT;
            end else if (i_tok.cls == hmd_pkg::CLS_IDENT) begin
                act = i_tok.ident_ok ? hmd_pkg::ACT_IDENT : hmd_pkg::ACT_ABORT;
            end else if (i_tok.cls == hmd_pkg::CLS_STLS) begin
                act = hmd_pkg::ACT_UPGRADE;
            end else if (i_tok.cls == hmd_pkg::CLS_UNKNOWN) begin
                act = hmd_pkg::ACT_ABORT;
            end else begin
                act = hmd_pkg::ACT_DELIVER;
            end
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            hmd_pkg::PH_RUN: begin
                if (act == hmd_pkg::ACT_ABORT) begin
                    n_phase = hmd_pkg::PH_ABORTED;
                end else if (act == hmd_pkg::ACT_UPGRADE) begin
                    n_phase = hmd_pkg::PH_UPGRADED;
                end
            end
            hmd_pkg::PH_ABORTED:  n_phase = hmd_pkg::PH_ABORTED;
            hmd_pkg::PH_UPGRADED: n_phase = hmd_pkg::PH_UPGRADED;
            default:              n_phase = hmd_pkg::PH_ABORTED;
        endcase
    end

    // Result fields and session registers for the byte at the queue head.
    always_comb begin
        n_pv    = 1'b0;
        n_pb    = 8'd0;
        n_cls   = 3'd0;
        n_end   = 1'b0;
        n_act   = hmd_pkg::ACT_NONE;
        n_fwd   = 1'b0;
        n_ident = r_ident;
        n_ver   = r_ver;
        case (r_phase)
            hmd_pkg::PH_RUN: begin
                if (i_tok.is_payload) begin
                    n_pv = 1'b1;
                    n_pb = i_tok.data;
                end
                if (i_tok.is_payload || i_tok.is_end) begin
                    n_cls = i_tok.cls;
                end
                n_end = i_tok.is_end;
                n_act = act;
                if (act == hmd_pkg::ACT_IDENT) begin
                    n_ident = 1'b1;
                    n_ver   = i_tok.version;
                end
            end
            hmd_pkg::PH_UPGRADED: begin
                n_fwd = 1'b1;
                n_pb  = i_tok.data;
            end
            default: begin
                n_pv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hmd_pkg::PH_RUN;
            r_ident     <= 1'b0;
            r_ver       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase <= n_phase;
                r_ident <= n_ident;
                r_ver   <= n_ver;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_pv   <= n_pv;
            r_pb   <= n_pb;
            r_cls  <= n_cls;
            r_end  <= n_end;
            r_act  <= n_act;
            r_fwd  <= n_fwd;
            r_rver <= n_ver;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.payload_valid  = r_pv;
    assign o_res.payload_byte   = r_pb;
    assign o_res.msg_class      = r_cls;
    assign o_res.msg_end        = r_end;
    assign o_res.action         = r_act;
    assign o_res.remote_version = r_rver;
    assign o_res.forwarded      = r_fwd;

endmodule

@@ rtl/handshake_message_deframer.sv @@
// Top level of the handshake message deframer.
//
//   Channel  Direction  Carries                                    One request is
//   i_rx     in         rx_byte                                    one received byte
//   o_res    out        payload, class, frame end, action, version one result per byte
//
// The block sustains one byte per cycle in and one result per cycle out while
// the output is not stalled. An accepted byte is stored in the queue and then
// in the result register; the framing front before the queue is combinational.
// Reset is synchronous and active low; it returns framing to the first header
// byte, clears identification and the latched version, and empties the queue.
// Either side may stall on its own: the queue absorbs a stall at the output
// while the front keeps taking bytes until the queue is full.
`timescale 1ns / 1ps
module handshake_message_deframer #(
    parameter int QueueDepth = hmd_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hmd_byte_if.sink     i_rx,
    hmd_result_if.source o_res
);

    // The front does all framing: it counts header bytes, assembles the type
    // and length, counts payload bytes, checks the identification signature
    // and captures the version. None of that depends on a frame's verdict,
    // because after an abort or an upgrade the front's view is ignored.
    logic            front_valid;
    logic            front_ready;
    hmd_pkg::t_token front_tok;

    // The back holds the session state: whether the peer has identified, the
    // latched version, and the terminal aborted and upgraded phases.
    logic            back_valid;
    logic            back_ready;
    hmd_pkg::t_token back_tok;

    hmd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_q_ready (front_ready),
        .o_q_valid (front_valid),
        .o_tok     (front_tok)
    );

    hmd_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_tok   (front_tok),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_tok    (back_tok)
    );

    hmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (back_valid),
        .o_tok_ready (back_ready),
        .i_tok       (back_tok),
        .o_res       (o_res)
    );

endmodule

@@ rtl/hmd_checker.sv @@
// Port-level checker for the handshake message deframer and its bind.
`timescale 1ns / 1ps
`include "handshake_message_deframer_assert.svh"
module hmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_payload_valid,
    input logic [7:0]  i_payload_byte,
    input logic        i_msg_end,
    input logic [2:0]  i_action,
    input logic        i_forwarded
);

    logic has_action;
    logic carries_frame;
    logic out_fire;
    logic out_stall;
    logic out_upgraded;

    assign has_action    = (i_action != hmd_pkg::ACT_NONE);
    assign carries_frame = i_payload_valid || i_msg_end;
    assign out_fire      = i_out_valid && i_out_ready;
    assign out_stall     = i_out_valid && !i_out_ready;
    assign out_upgraded  = i_forwarded || (i_action == hmd_pkg::ACT_UPGRADE);

    // An action is reported only on the byte that ends a frame.
    `HMD_ASSERT_NOW(a_action_on_end, i_clk, i_rst_n, i_out_valid && has_action, i_msg_end)

    // Raw forwarded bytes never carry frame information.
    `HMD_ASSERT_NOW(a_fwd_is_raw, i_clk, i_rst_n, i_out_valid && i_forwarded, !carries_frame)

    // Once the stream is upgraded, every later result is forwarded raw.
    `HMD_ASSERT_NEXT(a_upgrade_sticks, i_clk, i_rst_n, out_fire && out_upgraded, !i_out_valid || i_forwarded)

    // A stalled result holds its byte.
    `HMD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_payload_byte))

endmodule

bind handshake_message_deframer hmd_checker u_hmd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_payload_valid (o_res.payload_valid),
    .i_payload_byte  (o_res.payload_byte),
    .i_msg_end       (o_res.msg_end),
    .i_action        (o_res.action),
    .i_forwarded     (o_res.forwarded)
);

@@ sim/handshake_message_deframer_test.sv @@
// Self-checking testbench that drives framed byte streams through the deframer.
`timescale 1ns / 1ps
module handshake_message_deframer_test;

    // Four-character type codes, indexed by class (ASCII, big-endian on the wire).
    localparam logic [31:0] FRAME_CODES [7] = '{
        32'h64736D73, 32'h666E616D, 32'h61767472, 32'h70756269,
        32'h7075626B, 32'h70616972, 32'h73746C73
    };
    // Fixed eight-byte signature that opens every identification payload.
    localparam logic [63:0] IDENT_SIGNATURE = 64'h4465_736B_656D_6573;
    localparam logic [15:0] IDENT_MIN_BYTES = 16'd10;
    localparam int          RANDOM_BYTES    = 430;
    localparam int          TRAILING_BYTES  = 40;

    // One result as seen on the output channel.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [2:0]  msg_class;
        logic        msg_end;
        logic [2:0]  action;
        logic [15:0] remote_version;
        logic        forwarded;
    } t_result;

    // How the stream is brought to its terminal state; only one per run.
    typedef enum int {
        ENDING_EARLY_FRAME,
        ENDING_SHORT_IDENT,
        ENDING_BAD_SIGNATURE,
        ENDING_UNKNOWN_TYPE,
        ENDING_UPGRADE
    } t_ending;

    // Tracks the deframer state, predicts the result of every accepted byte
    // and checks the results in arrival order.
    class frame_result_tracker;
        hmd_pkg::t_phase phase;
        bit              in_payload;
        logic [2:0]      hdr_count;
        logic [31:0]     frame_code;
        logic [15:0]     frame_len;
        logic [15:0]     payload_pos;
        bit              ident_done;
        bit              sig_match;
        logic [15:0]     version_seen;
        logic [15:0]     version_latched;
        t_result         due_results[$];
        int unsigned     failures;

        function new();
            phase           = hmd_pkg::PH_RUN;
            in_payload      = 1'b0;
            hdr_count       = '0;
            frame_code      = '0;
            frame_len       = '0;
            payload_pos     = '0;
            ident_done      = 1'b0;
            sig_match       = 1'b1;
            version_seen    = '0;
            version_latched = '0;
            failures        = 0;
        endfunction

        function hmd_pkg::t_class type_class(logic [31:0] code);
            hmd_pkg::t_class c;
            c = hmd_pkg::CLS_UNKNOWN;
            for (int i = 6; i >= 0; i--) begin
                if (code == FRAME_CODES[i]) begin
                    c = hmd_pkg::t_class'(i[2:0]);
                end
            end
            return c;
        endfunction

        // Verdict on a completed frame; also selects the phase that follows.
        function hmd_pkg::t_action close_frame(hmd_pkg::t_class cls);
            hmd_pkg::t_action act;
            if (!ident_done && cls != hmd_pkg::CLS_IDENT) begin
                act = hmd_pkg::ACT_ABORT;
            end else if (cls == hmd_pkg::CLS_IDENT) begin
                if (frame_len >= IDENT_MIN_BYTES && sig_match) begin
                    ident_done      = 1'b1;
                    version_latched = version_seen;
                    act             = hmd_pkg::ACT_IDENT;
                end else begin
                    act = hmd_pkg::ACT_ABORT;
                end
            end else if (cls == hmd_pkg::CLS_STLS) begin
                act = hmd_pkg::ACT_UPGRADE;
            end else if (cls == hmd_pkg::CLS_UNKNOWN) begin
                act = hmd_pkg::ACT_ABORT;
            end else begin
                act = hmd_pkg::ACT_DELIVER;
            end
            if (act == hmd_pkg::ACT_ABORT) begin
                phase = hmd_pkg::PH_ABORTED;
            end else if (act == hmd_pkg::ACT_UPGRADE) begin
                phase = hmd_pkg::PH_UPGRADED;
            end else begin
                phase = hmd_pkg::PH_RUN;
            end
            in_payload = 1'b0;
            hdr_count  = '0;
            return act;
        endfunction

        function void take_byte(logic [7:0] b);
            t_result         r;
            hmd_pkg::t_class cls;
            r   = '0;
            cls = hmd_pkg::CLS_IDENT;
            if (phase == hmd_pkg::PH_UPGRADED) begin
                r.forwarded    = 1'b1;
                r.payload_byte = b;
            end else if (phase == hmd_pkg::PH_RUN && !in_payload) begin
                if (hdr_count < 3'd4) begin
                    frame_code = {frame_code[23:0], b};
                end else begin
                    frame_len = {frame_len[7:0], b};
                end
                if (hdr_count >= 3'd5) begin
                    payload_pos  = '0;
                    sig_match    = 1'b1;
                    version_seen = '0;
                    if (frame_len == 16'd0) begin
                        // Empty frame: the last header byte closes it.
                        cls         = type_class(frame_code);
                        r.msg_class = cls;
                        r.msg_end   = 1'b1;
                        r.action    = close_frame(cls);
                    end else begin
                        in_payload = 1'b1;
                        hdr_count  = '0;
                    end
                end else begin
                    hdr_count = hdr_count + 3'd1;
                end
            end else if (phase == hmd_pkg::PH_RUN) begin
                cls             = type_class(frame_code);
                r.msg_class     = cls;
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                if (payload_pos < 16'd8) begin
                    if (b != IDENT_SIGNATURE[63 - 8 * payload_pos[2:0] -: 8]) begin
                        sig_match = 1'b0;
                    end
                end else if (payload_pos == 16'd8) begin
                    version_seen = {b, 8'h00};
                end else if (payload_pos == 16'd9) begin
                    version_seen[7:0] = b;
                end
                payload_pos = payload_pos + 16'd1;
                if (payload_pos == frame_len) begin
                    r.msg_end = 1'b1;
                    r.action  = close_frame(cls);
                end
            end
            // In the aborted phase the byte is dropped and only the version shows.
            r.remote_version = version_latched;
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                failures++;
                $display("%0t: result expected none, got %0h", $time, got);
            end else begin
                want = due_results.pop_front();
                compare_field("payload_valid", 16'(want.payload_valid),
                              16'(got.payload_valid));
                compare_field("payload_byte", 16'(want.payload_byte),
                              16'(got.payload_byte));
                compare_field("msg_class", 16'(want.msg_class), 16'(got.msg_class));
                compare_field("msg_end", 16'(want.msg_end), 16'(got.msg_end));
                compare_field("action", 16'(want.action), 16'(got.action));
                compare_field("remote_version", want.remote_version, got.remote_version);
                compare_field("forwarded", 16'(want.forwarded), 16'(got.forwarded));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hmd_byte_if   rx_chan ();
    hmd_result_if res_chan ();

    handshake_message_deframer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_chan),
        .o_res   (res_chan)
    );

    frame_result_tracker tracker;
    logic [7:0]          body[$];
    int                  bytes_sent;
    // 0: sender idles less than receiver, 1: the other way round, 2: no idling.
    int                  idle_mode;
    t_ending             ending;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        case (idle_mode)
            0:       res_chan.ready <= ($urandom_range(0, 99) >= 56);
            1:       res_chan.ready <= ($urandom_range(0, 99) >= 33);
            default: res_chan.ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_chan.valid && res_chan.ready) begin
            tracker.match_result({res_chan.payload_valid, res_chan.payload_byte,
                                  res_chan.msg_class, res_chan.msg_end, res_chan.action,
                                  res_chan.remote_version, res_chan.forwarded});
        end
    end

    // Holds the sender off until every request sent so far has its result.
    task automatic let_results_drain();
        rx_chan.valid <= 1'b0;
        @(negedge i_clk);
        while (tracker.due_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic bit sender_idles();
        case (idle_mode)
            0:       return $urandom_range(0, 99) < 33;
            1:       return $urandom_range(0, 99) < 56;
            default: return 1'b0;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        if (idle_mode == 0 && bytes_sent >= RANDOM_BYTES / 3) begin
            let_results_drain();
            idle_mode = 1;
        end else if (idle_mode == 1 && bytes_sent >= 2 * RANDOM_BYTES / 3) begin
            let_results_drain();
            idle_mode = 2;
        end
        while (sender_idles()) begin
            rx_chan.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_chan.ready) begin
            @(posedge i_clk);
        end
        tracker.take_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Sends a header for the staged body and then the body itself.
    task automatic send_frame(input logic [31:0] code);
        logic [15:0] len;
        len = 16'(body.size());
        for (int i = 3; i >= 0; i--) begin
            send_byte(code[8 * i +: 8]);
        end
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        foreach (body[i]) begin
            send_byte(body[i]);
        end
    endtask

    task automatic fill_random(input int n);
        body.delete();
        repeat (n) begin
            body.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Identification body: signature, version, then extra bytes. A spoiled
    // signature has one random bit flipped in one random signature byte.
    task automatic fill_ident(input logic [15:0] ver, input int extra, input bit spoil);
        int idx;
        body.delete();
        for (int i = 0; i < 8; i++) begin
            body.push_back(IDENT_SIGNATURE[63 - 8 * i -: 8]);
        end
        if (spoil) begin
            idx       = $urandom_range(0, 7);
            body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        body.push_back(ver[15:8]);
        body.push_back(ver[7:0]);
        repeat (extra) begin
            body.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly short payloads, with the odd long one.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(0, 12);
        end else if (r < 95) begin
            return $urandom_range(13, 40);
        end
        return $urandom_range(100, 300);
    endfunction

    function automatic logic [31:0] unknown_code();
        logic [31:0] code;
        code = FRAME_CODES[$urandom_range(0, 6)] ^ (32'h1 << $urandom_range(0, 31));
        while (tracker.type_class(code) != hmd_pkg::CLS_UNKNOWN) begin
            code = $urandom();
        end
        return code;
    endfunction

    initial begin
        int r;
        tracker         = new();
        bytes_sent      = 0;
        idle_mode       = 0;
        i_rst_n         = 1'b0;
        rx_chan.valid   = 1'b0;
        rx_chan.rx_byte = 8'h00;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        r = $urandom_range(0, 7);
        case (r)
            0:       ending = ENDING_EARLY_FRAME;
            1:       ending = ENDING_SHORT_IDENT;
            2:       ending = ENDING_BAD_SIGNATURE;
            3:       ending = ENDING_UNKNOWN_TYPE;
            default: ending = ENDING_UPGRADE;
        endcase

        if (ending == ENDING_EARLY_FRAME) begin
            // Anything but identification first, start-TLS included, must abort.
            fill_random($urandom_range(0, 12));
            if ($urandom_range(0, 7) == 0) begin
                send_frame(unknown_code());
            end else begin
                send_frame(FRAME_CODES[$urandom_range(1, 6)]);
            end
        end else begin
            // Minimal identification frame with byte extremes in the version,
            // then an empty frame judged on its last header byte.
            fill_ident(16'hFF00, 0, 1'b0);
            send_frame(FRAME_CODES[hmd_pkg::CLS_IDENT]);
            body.delete();
            send_frame(FRAME_CODES[hmd_pkg::CLS_AVATAR]);

            while (bytes_sent < RANDOM_BYTES) begin
                if ($urandom_range(0, 99) < 12) begin
                    // Repeated identification latches a fresh version.
                    fill_ident(16'($urandom_range(0, 65535)), $urandom_range(0, 6), 1'b0);
                    send_frame(FRAME_CODES[hmd_pkg::CLS_IDENT]);
                end else begin
                    fill_random(pick_length());
                    send_frame(FRAME_CODES[$urandom_range(1, 5)]);
                end
            end

            case (ending)
                ENDING_SHORT_IDENT: begin
                    fill_ident(16'($urandom_range(0, 65535)), 0, 1'b0);
                    r = $urandom_range(0, 9);
                    while (body.size() > r) begin
                        void'(body.pop_back());
                    end
                    send_frame(FRAME_CODES[hmd_pkg::CLS_IDENT]);
                end
                ENDING_BAD_SIGNATURE: begin
                    fill_ident(16'($urandom_range(0, 65535)), $urandom_range(0, 4), 1'b1);
                    send_frame(FRAME_CODES[hmd_pkg::CLS_IDENT]);
                end
                ENDING_UNKNOWN_TYPE: begin
                    fill_random(pick_length());
                    send_frame(unknown_code());
                end
                default: begin
                    fill_random($urandom_range(0, 8));
                    send_frame(FRAME_CODES[hmd_pkg::CLS_STLS]);
                end
            endcase
        end

        // Bytes after the terminal frame are dropped or forwarded raw. A run
        // that ends early keeps sending until it reaches the usual length.
        repeat (TRAILING_BYTES) begin
            send_byte(8'($urandom_range(0, 255)));
        end
        while (bytes_sent < RANDOM_BYTES + TRAILING_BYTES) begin
            send_byte(8'($urandom_range(0, 255)));
        end

        let_results_drain();
        repeat (10) @(negedge i_clk);
        if (tracker.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
